/* rtl/upe_pkg.sv */
// Shared types, codes and character helpers for the escape encoder.
`default_nettype none
package upe_pkg;

    localparam logic [1:0] MODE_PERCENT = 2'd0;
    localparam logic [1:0] MODE_CHEX    = 2'd1;
    localparam logic [1:0] MODE_UNICODE = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;

    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,
        KIND_PCT  = 2'd1,
        KIND_CHEX = 2'd2,
        KIND_UNI  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_head;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {4'd0, nib};
        end else begin
            d = CH_UPPER_A + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

    function automatic logic passes_percent(input logic [7:0] b);
        logic p;
        p = ((b >= CH_ZERO) && (b <= CH_NINE)) ||
            ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
            ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
            (b == CH_DOLLAR) || (b == CH_DASH) || (b == CH_UNDER) ||
            (b == CH_DOT) || (b == CH_PLUS) || (b == CH_BANG) ||
            (b == CH_STAR) || (b == CH_QUOTE) || (b == CH_LPAREN) ||
            (b == CH_RPAREN);
        return p;
    endfunction

    function automatic logic [2:0] run_last(input t_kind kind);
        logic [2:0] n;
        unique case (kind)
            KIND_LIT:  n = 3'd0;
            KIND_PCT:  n = 3'd2;
            KIND_CHEX: n = 3'd3;
            KIND_UNI:  n = 3'd5;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] run_char(input t_kind kind, input logic [7:0] b,
                                            input logic [2:0] idx);
        logic [7:0] c;
        logic [7:0] hi;
        logic [7:0] lo;
        hi = hex_digit(b[7:4]);
        lo = hex_digit(b[3:0]);
        c  = b;
        unique case (kind)
            KIND_LIT: c = b;
            KIND_PCT: begin
                unique case (idx)
                    3'd0:    c = CH_PERCENT;
                    3'd1:    c = hi;
                    default: c = lo;
                endcase
            end
            KIND_CHEX: begin
                unique case (idx)
                    3'd0:    c = CH_BACKSLASH;
                    3'd1:    c = CH_X;
                    3'd2:    c = hi;
                    default: c = lo;
                endcase
            end
            KIND_UNI: begin
                unique case (idx)
                    3'd0:    c = CH_BACKSLASH;
                    3'd1:    c = CH_U;
                    3'd2:    c = CH_ZERO;
                    3'd3:    c = CH_ZERO;
                    3'd4:    c = hi;
                    default: c = lo;
                endcase
            end
            default: c = b;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/upe_front.sv */
// Front end: mode register, byte acceptance and classification into run descriptors.
`default_nettype none
module upe_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_escape_mode,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_q_full,
    output logic               o_push,
    output upe_pkg::t_desc     o_desc
);
    import upe_pkg::*;

    logic [1:0] r_escape_mode;
    logic [1:0] n_escape_mode;
    t_kind      kind;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_escape_mode = r_escape_mode;
        if (i_cfg_valid) begin
            n_escape_mode = i_cfg_escape_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_mode <= MODE_PERCENT;
        end else begin
            r_escape_mode <= n_escape_mode;
        end
    end

    always_comb begin
        kind = KIND_LIT;
        unique case (r_escape_mode)
            MODE_PERCENT: kind = passes_percent(i_in_byte) ? KIND_LIT : KIND_PCT;
            MODE_CHEX:    kind = KIND_CHEX;
            MODE_UNICODE: kind = i_in_byte[7] ? KIND_LIT : KIND_UNI;
            default:      kind = KIND_LIT;
        endcase
    end

    // drop the transaction in the unused mode
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && (r_escape_mode != MODE_UNUSED);
    assign o_desc     = '{kind: kind, data: i_in_byte};

endmodule
`default_nettype wire

/* rtl/upe_queue.sv */
// Descriptor queue between front end and emitter.
`default_nettype none
module upe_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire upe_pkg::t_desc i_desc,
    input  wire logic          i_pop,
    output logic               o_full,
    output upe_pkg::t_head     o_head
);
    import upe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    assign o_full       = (r_count == FULL_CNT);
    assign o_head.valid = (r_count != '0);
    assign o_head.desc  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

/* rtl/upe_back.sv */
// Emitter: walks each run into the output register, one character per unstalled cycle.
`default_nettype none
module upe_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire upe_pkg::t_head i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [7:0]         o_out_char,
    output logic               o_out_last_of_run
);
    import upe_pkg::*;

    logic       r_busy;
    logic       n_busy;
    t_desc      r_cur;
    t_desc      n_cur;
    logic [2:0] r_idx;
    logic [2:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_out_char;
    logic [7:0] n_out_char;
    logic       r_out_last;
    logic       n_out_last;

    t_desc      src;
    logic [2:0] src_idx;
    logic       have;
    logic       adv;
    logic       last;

    assign src     = r_busy ? r_cur : i_head.desc;
    assign src_idx = r_busy ? r_idx : 3'd0;
    assign have    = r_busy || i_head.valid;
    assign adv     = !r_out_valid || !i_out_stall;
    assign last    = (src_idx == run_last(src.kind));
    assign o_pop   = adv && !r_busy && i_head.valid;

    always_comb begin
        n_busy      = r_busy;
        n_cur       = r_cur;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (adv) begin
            n_out_valid = have;
            if (have) begin
                n_out_char = run_char(src.kind, src.data, src_idx);
                n_out_last = last;
                n_busy     = !last;
                n_cur      = src;
                n_idx      = src_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_char        = r_out_char;
    assign o_out_last_of_run = r_out_last;

endmodule
`default_nettype wire

/* rtl/url_percent_escape_encoder.sv */
// Top level of the percent / C / unicode escape encoder.
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_byte) takes one raw byte per
//   transaction. Output channel (o_out_valid, i_out_stall, o_out_char,
//   o_out_last_of_run) gives one ASCII character per transaction, with
//   o_out_last_of_run set on the final character of each byte's run.
//   Config channel (i_cfg_valid, o_cfg_ready, i_cfg_escape_mode) writes the
//   mode: 0 percent, 1 C hex, 2 unicode; mode 3 drops bytes. Write it only
//   while the block is idle. o_cfg_ready is always high.
// Timing:
//   The first character of a byte passes through the descriptor queue and
//   then the output register before it is valid to the receiver.
//   Run lengths are 1, 3, 4 or 6 characters; the emitter produces one
//   character per cycle while i_out_stall is low.
//   A DEPTH-entry descriptor queue holds accepted bytes while a run drains.
// Reset and stall:
//   Synchronous active-low reset empties the queue and output register and
//   sets percent mode. While i_out_stall is high a valid output holds;
//   once the queue fills, o_in_stall rises.
`default_nettype none
module url_percent_escape_encoder #(
    parameter int DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_escape_mode,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_out_last_of_run
);
    import upe_pkg::*;

    logic  q_full;
    logic  push;
    logic  pop;
    t_desc desc;
    t_head head;

    upe_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_escape_mode (i_cfg_escape_mode),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_byte         (i_in_byte),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_desc            (desc)
    );

    upe_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    upe_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_char        (o_out_char),
        .o_out_last_of_run (o_out_last_of_run)
    );

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for url_percent_escape_encoder: table-driven and random bytes, all modes.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import upe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 75;
    localparam int NUM_DIR_ROWS  = 25;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_esc_char;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  data;
        logic        typed;
        logic [47:0] text;
        logic [2:0]  count;
    } t_dir_row;

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_cfg_valid       = 1'b0;
    logic [1:0] i_cfg_escape_mode = MODE_PERCENT;
    logic       i_in_valid        = 1'b0;
    logic [7:0] i_in_byte         = 8'h00;
    logic       i_out_stall       = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_out_last_of_run;

    t_esc_char  pending_chars[$];
    logic [7:0] run_buf[$];
    logic [1:0] esc_mode      = MODE_PERCENT;
    int         in_idle_pct   = 0;
    int         out_stall_pct = 0;
    logic       hold_off      = 1'b0;
    logic       pressure_go   = 1'b0;
    int         mismatches    = 0;
    int         cycles        = 0;

    t_dir_row dir_rows [NUM_DIR_ROWS] = '{
        '{MODE_PERCENT, 8'h41, 1'b1, "A",   3'd1},
        '{MODE_PERCENT, 8'h7A, 1'b1, "z",   3'd1},
        '{MODE_PERCENT, 8'h30, 1'b1, "0",   3'd1},
        '{MODE_PERCENT, 8'h39, 1'b1, "9",   3'd1},
        '{MODE_PERCENT, 8'h24, 1'b1, "$",   3'd1},
        '{MODE_PERCENT, 8'h29, 1'b1, ")",   3'd1},
        '{MODE_PERCENT, 8'h20, 1'b1, "%20", 3'd3},
        '{MODE_PERCENT, 8'h00, 1'b1, "%00", 3'd3},
        '{MODE_PERCENT, 8'hFF, 1'b1, "%FF", 3'd3},
        '{MODE_PERCENT, 8'h2F, 1'b0, 48'h0, 3'd0},
        '{MODE_PERCENT, 8'h40, 1'b0, 48'h0, 3'd0},
        '{MODE_PERCENT, 8'h5B, 1'b0, 48'h0, 3'd0},
        '{MODE_PERCENT, 8'h60, 1'b0, 48'h0, 3'd0},
        '{MODE_PERCENT, 8'h7B, 1'b0, 48'h0, 3'd0},
        '{MODE_CHEX,    8'h00, 1'b1, "\\x00", 3'd4},
        '{MODE_CHEX,    8'hFF, 1'b1, "\\xFF", 3'd4},
        '{MODE_CHEX,    8'h5A, 1'b0, 48'h0, 3'd0},
        '{MODE_CHEX,    8'hA5, 1'b0, 48'h0, 3'd0},
        '{MODE_UNICODE, 8'h7F, 1'b1, "\\u007F", 3'd6},
        '{MODE_UNICODE, 8'h80, 1'b1, 48'h80, 3'd1},
        '{MODE_UNICODE, 8'hFF, 1'b1, 48'hFF, 3'd1},
        '{MODE_UNICODE, 8'h00, 1'b1, "\\u0000", 3'd6},
        '{MODE_UNICODE, 8'h3C, 1'b0, 48'h0, 3'd0},
        '{MODE_UNUSED,  8'h55, 1'b1, 48'h0, 3'd0},
        '{MODE_UNUSED,  8'hAA, 1'b1, 48'h0, 3'd0}
    };

    url_percent_escape_encoder u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_escape_mode (i_cfg_escape_mode),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_byte         (i_in_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_char        (o_out_char),
        .o_out_last_of_run (o_out_last_of_run)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + 8'(nib);
        end else begin
            c = 8'h37 + 8'(nib);
        end
        return c;
    endfunction

    function automatic logic is_unreserved(input logic [7:0] b);
        logic ok;
        ok = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A) ||
             b == CH_DOLLAR || b == CH_DASH || b == CH_UNDER || b == CH_DOT ||
             b == CH_PLUS || b == CH_BANG || b == CH_STAR || b == CH_QUOTE ||
             b == CH_LPAREN || b == CH_RPAREN;
        return ok;
    endfunction

    function automatic void predict_escape(input logic [1:0] mode, input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = hex_char(b[7:4]);
        lo = hex_char(b[3:0]);
        run_buf.delete();
        case (mode)
            MODE_PERCENT: begin
                if (is_unreserved(b)) begin
                    run_buf.push_back(b);
                end else begin
                    run_buf = '{CH_PERCENT, hi, lo};
                end
            end
            MODE_CHEX: run_buf = '{CH_BACKSLASH, CH_X, hi, lo};
            MODE_UNICODE: begin
                if (b[7]) begin
                    run_buf.push_back(b);
                end else begin
                    run_buf = '{CH_BACKSLASH, CH_U, CH_ZERO, CH_ZERO, hi, lo};
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_run();
        for (int k = 0; k < run_buf.size(); k++) begin
            pending_chars.push_back('{run_buf[k], k == run_buf.size() - 1});
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input logic [47:0] text, input logic [2:0] count);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (typed) begin
            run_buf.delete();
            for (int k = 0; k < count; k++) begin
                run_buf.push_back(text[8 * (count - 1 - k) +: 8]);
            end
        end else begin
            predict_escape(esc_mode, b);
        end
        queue_run();
    endtask

    task automatic write_mode(input logic [1:0] m);
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_escape_mode <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        esc_mode = m;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= hold_off || ($urandom_range(99) < out_stall_pct);
    end

    // hold the output off long enough for the input side to back up
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_esc_char exp_c;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected transaction: out_char %h last_of_run %b",
                       o_out_char, o_out_last_of_run);
                mismatches++;
            end else begin
                exp_c = pending_chars.pop_front();
                if (o_out_char !== exp_c.ch) begin
                    $error("out_char: expected %h, got %h", exp_c.ch, o_out_char);
                    mismatches++;
                end
                if (o_out_last_of_run !== exp_c.last) begin
                    $error("last_of_run: expected %b, got %b", exp_c.last,
                           o_out_last_of_run);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int         counted;
        int         chunk;
        int         run_len;
        logic [1:0] m;
        logic [7:0] b;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].mode != esc_mode) write_mode(dir_rows[r].mode);
            send_byte(dir_rows[r].data, dir_rows[r].typed, dir_rows[r].text,
                      dir_rows[r].count);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 77; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 77; end
                default: begin in_idle_pct = 28; out_stall_pct = 28; end
            endcase
            counted = 0;
            chunk   = 0;
            while (counted < PHASE_ITEMS) begin
                m = 2'(chunk + ph);
                write_mode(m);
                if (ph == 0 && chunk == 0) pressure_go = 1'b1;
                run_len = (m == MODE_UNUSED) ? 4 : 15;
                for (int k = 0; k < run_len; k++) begin
                    if ($urandom_range(1)) begin
                        b = 8'($urandom_range(255));
                    end else begin
                        b = 8'($urandom_range(8'h7E, 8'h20));
                    end
                    send_byte(b, 1'b0, 48'h0, 3'd0);
                    if (m != MODE_UNUSED) counted++;
                end
                chunk++;
            end
        end

        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
